@@ src/ring_modulator_nco_mix_core_macros.svh @@
// assertion macros shared by the checker
`ifndef RING_MODULATOR_NCO_MIX_CORE_MACROS_SVH
`define RING_MODULATOR_NCO_MIX_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RMN_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("ring modulator check failed");

// next-cycle implication, disabled while reset is low
`define RMN_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("ring modulator check failed");

`endif

@@ src/rmn_pkg.sv @@
// shared types, constants and the sine table function of the ring modulator
package rmn_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 24;

  localparam int PHASE_BITS    = 32;
  localparam int MIX_BITS      = 16;
  localparam int CARRIER_BITS  = 16;
  localparam int GAIN_BITS     = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_MIX         = 2'd1;

  localparam logic [PHASE_BITS-1:0] PHASE_INCREMENT_RESET = 32'd8947848;
  localparam logic [MIX_BITS-1:0]   WET_MIX_RESET         = 16'd16384;
  localparam logic [MIX_BITS-1:0]   MIX_ONE               = 16'h8000;
  localparam logic [63:0]           HALF_PI_Q30           = 64'd1686629713;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_increment;
    logic [MIX_BITS-1:0]   wet_mix;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CARRIER,
    BK_LEFT,
    BK_RIGHT,
    BK_DONE
  } back_state_e;

  // q30 taylor series of sin(x), truncated terms, scaled to 32767
  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] scaled;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) <<< 30)) begin
      sum = longint'(1) <<< 30;
    end
    scaled = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return scaled[15:0];
  endfunction

endpackage

@@ src/rmn_fifo.sv @@
// two-entry queue between the front and back parts
module rmn_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0]                  mem_q [rmn_pkg::QUEUE_DEPTH];
  logic [rmn_pkg::QUEUE_PTR_BITS-1:0] wptr_q, wptr_d;
  logic [rmn_pkg::QUEUE_PTR_BITS-1:0] rptr_q, rptr_d;
  logic [rmn_pkg::QUEUE_PTR_BITS:0]   count_q, count_d;
  logic                              push_fire, pop_fire;

  assign push_ready_o = (count_q != (rmn_pkg::QUEUE_PTR_BITS+1)'(rmn_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = push_fire ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_fire ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/rmn_front.sv @@
// phase accumulator and carrier table addressing for each accepted frame
module rmn_front #(
  parameter int SAMPLE_BITS      = rmn_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = rmn_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int IDX_BITS        = $clog2(SINE_TABLE_DEPTH),
  localparam int ENTRY_W         = 1 + IDX_BITS + 2 * SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2*SAMPLE_BITS-1:0]        in_data_i,
  input  logic [rmn_pkg::PHASE_BITS-1:0]  phase_increment_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output logic [ENTRY_W-1:0]              push_data_o
);

  localparam int SCALE_W = 30 + IDX_BITS;

  logic [rmn_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic [SCALE_W-1:0]             scaled;
  logic [IDX_BITS-1:0]            idx_raw, idx;
  logic                           fire;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign fire         = in_valid_i && push_ready_i;

  always_comb begin
    scaled  = SCALE_W'(phase_q[29:0]) * SCALE_W'(SINE_TABLE_DEPTH);
    idx_raw = scaled[30 +: IDX_BITS];
    // odd quadrants run the quarter table backwards
    idx     = phase_q[30] ? IDX_BITS'(SINE_TABLE_DEPTH - 1) - idx_raw : idx_raw;
    phase_d = fire ? phase_q + phase_increment_i : phase_q;
  end

  assign push_data_o = {phase_q[31], idx, in_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ src/rmn_back.sv @@
// carrier lookup, mix gain and shared multiplier with rounding and saturation
module rmn_back #(
  parameter int SAMPLE_BITS      = rmn_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = rmn_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int IDX_BITS        = $clog2(SINE_TABLE_DEPTH),
  localparam int ENTRY_W         = 1 + IDX_BITS + 2 * SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [ENTRY_W-1:0]            pop_data_i,
  input  logic [rmn_pkg::MIX_BITS-1:0]  wet_mix_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_BITS-1:0]        out_left_o,
  output logic [SAMPLE_BITS-1:0]        out_right_o
);

  localparam int PROD_W = SAMPLE_BITS + rmn_pkg::GAIN_BITS;
  localparam int Q_W    = PROD_W + 1 - 30;
  localparam logic signed [Q_W-1:0] QMAX =
    {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0] QMIN =
    {{(Q_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [PROD_W:0] ROUND_HALF = {{(PROD_W-29){1'b0}}, 1'b1, 29'b0};

  // quarter-wave sine table
  logic [rmn_pkg::CARRIER_BITS-1:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] X =
      (rmn_pkg::HALF_PI_Q30 * 64'(2 * k + 1)) / (2 * SINE_TABLE_DEPTH);
    assign rom[k] = rmn_pkg::quarter_sine(X);
  end

  rmn_pkg::back_state_e state_q, state_d;

  logic                                   pop_fire, load_out;
  logic [SAMPLE_BITS-1:0]                 left_q, right_q;
  logic [rmn_pkg::CARRIER_BITS-1:0]       rom_q;
  logic                                   neg_q;
  logic signed [rmn_pkg::CARRIER_BITS-1:0] carrier;
  logic [rmn_pkg::MIX_BITS-1:0]           mix;
  logic signed [32:0]                     wet_part, dry_part, gain_sum;
  logic signed [rmn_pkg::GAIN_BITS-1:0]   gain_q;
  logic signed [SAMPLE_BITS-1:0]          mul_in;
  logic signed [PROD_W-1:0]               prod_q;
  logic signed [PROD_W:0]                 rounded;
  logic signed [Q_W-1:0]                  quot;
  logic [SAMPLE_BITS-1:0]                 sat;
  logic [SAMPLE_BITS-1:0]                 left_res_q;
  logic                                   out_valid_q;
  logic [SAMPLE_BITS-1:0]                 out_left_q, out_right_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rmn_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = rmn_pkg::BK_CARRIER;
        end
      end
      rmn_pkg::BK_CARRIER: state_d = rmn_pkg::BK_LEFT;
      rmn_pkg::BK_LEFT:    state_d = rmn_pkg::BK_RIGHT;
      rmn_pkg::BK_RIGHT:   state_d = rmn_pkg::BK_DONE;
      rmn_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = rmn_pkg::BK_IDLE;
        end
      end
      default: state_d = rmn_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = (state_q == rmn_pkg::BK_IDLE);
    load_out    = (state_q == rmn_pkg::BK_DONE) && (!out_valid_q || out_ready_i);
  end

  assign pop_fire = pop_valid_i && pop_ready_o;

  always_comb begin
    carrier  = neg_q ? (16'sd0 - $signed(rom_q)) : $signed(rom_q);
    mix      = (wet_mix_i > rmn_pkg::MIX_ONE) ? rmn_pkg::MIX_ONE : wet_mix_i;
    wet_part = carrier * $signed({1'b0, mix});
    dry_part = $signed({2'b00, 16'(rmn_pkg::MIX_ONE - mix), 15'b0});
    gain_sum = dry_part + wet_part;
    mul_in   = (state_q == rmn_pkg::BK_LEFT) ? $signed(left_q) : $signed(right_q);
    rounded  = $signed({prod_q[PROD_W-1], prod_q}) + ROUND_HALF;
    quot     = rounded[PROD_W:30];
    if (quot > QMAX) begin
      sat = SMAX;
    end else if (quot < QMIN) begin
      sat = SMIN;
    end else begin
      sat = quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      left_q  <= pop_data_i[SAMPLE_BITS-1:0];
      right_q <= pop_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
      rom_q   <= rom[pop_data_i[2*SAMPLE_BITS +: IDX_BITS]];
      neg_q   <= pop_data_i[ENTRY_W-1];
    end
    if (state_q == rmn_pkg::BK_CARRIER) begin
      gain_q <= gain_sum[rmn_pkg::GAIN_BITS-1:0];
    end
    if (state_q == rmn_pkg::BK_LEFT || state_q == rmn_pkg::BK_RIGHT) begin
      prod_q <= mul_in * gain_q;
    end
    if (state_q == rmn_pkg::BK_RIGHT) begin
      left_res_q <= sat;
    end
    if (load_out) begin
      out_left_q  <= left_res_q;
      out_right_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmn_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

endmodule

@@ src/ring_modulator_nco_mix_core.sv @@
// top level of the ring modulator with sine carrier and dry/wet mix
// usage:
//   s_axis carries one stereo frame per transaction, m_axis one mixed frame.
//   cfg writes phase_increment (index 0) or wet_mix (index 1); other indexes
//   are ignored. cfg_ready_o is always high; write only while the block is idle.
// timing:
//   an accepted frame passes the queue, then the back states idle, carrier, left,
//   right and done before it leaves; the back sequencer runs the table read,
//   gain product and one shared multiplier over both channels, one frame at a time.
//   a two-entry queue lets the input keep accepting while the back part works.
// reset:
//   phase returns to zero, registers to their defaults, queue and output empty.
// stall:
//   a frame waiting on m_axis holds its data; the back part then waits and the
//   queue fills, after which s_axis_tready drops.
module ring_modulator_nco_mix_core #(
  parameter int SAMPLE_BITS      = rmn_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = rmn_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int TDATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rmn_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [rmn_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [TDATA_W-1:0]                 s_axis_tdata,  // left_in, right_in
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [TDATA_W-1:0]                 m_axis_tdata   // left_out, right_out
);

  localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int ENTRY_W  = 1 + IDX_BITS + 2 * SAMPLE_BITS;

  rmn_pkg::cfg_t cfg_q, cfg_d;

  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]     push_data, pop_data;
  logic [SAMPLE_BITS-1:0] out_left, out_right;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rmn_pkg::CFG_PHASE_INCREMENT: cfg_d.phase_increment = cfg_data_i;
        rmn_pkg::CFG_WET_MIX:         cfg_d.wet_mix = cfg_data_i[rmn_pkg::MIX_BITS-1:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_increment <= rmn_pkg::PHASE_INCREMENT_RESET;
      cfg_q.wet_mix         <= rmn_pkg::WET_MIX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rmn_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .in_data_i         (s_axis_tdata[2*SAMPLE_BITS-1:0]),
    .phase_increment_i (cfg_q.phase_increment),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_data_o       (push_data)
  );

  rmn_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rmn_back #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .wet_mix_i   (cfg_q.wet_mix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_left_o  (out_left),
    .out_right_o (out_right)
  );

  assign m_axis_tdata = TDATA_W'({out_right, out_left});

endmodule

@@ src/rmn_checker.sv @@
// port-level checks of the ring modulator and their binding
`include "ring_modulator_nco_mix_core_macros.svh"

module rmn_checker #(
  parameter int SAMPLE_BITS = rmn_pkg::SAMPLE_BITS_DEF,
  localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // queue, back part and output register hold at most this many frames
  localparam logic [2:0] MAX_PENDING = 3'd4;

  logic [2:0] pending_q;
  logic       in_fire, out_fire, out_stall;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_fire && !out_fire) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `RMN_ASSERT_IMPLIES(a_cfg_always_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)
  `RMN_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `RMN_ASSERT_IMPLIES(a_no_invented_output, clk_i, rst_ni, m_axis_tvalid, pending_q != 3'd0)
  `RMN_ASSERT_IMPLIES(a_pending_bound, clk_i, rst_ni, 1'b1, pending_q <= MAX_PENDING)

endmodule

bind ring_modulator_nco_mix_core rmn_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rmn_checker (.*);
